@@ sv/swerve_module_kinematics_core_assert.svh @@
// ----------------------------------------------------------------------------
// swerve module kinematics assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef SWERVE_MODULE_KINEMATICS_CORE_ASSERT_SVH
`define SWERVE_MODULE_KINEMATICS_CORE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define SMK_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smk check failed");

// condition holds in the cycle after the trigger
`define SMK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smk check failed");

`endif

@@ sv/smk_pkg.sv @@
// ----------------------------------------------------------------------------
// smk_pkg
// types and constants of the swerve module kinematics core
// ----------------------------------------------------------------------------
`default_nettype none

package smk_pkg;

    localparam int XW   = 30;   // cordic x / y width
    localparam int AW   = 25;   // angle accumulator width, 1/32768 degree
    localparam int SW   = 21;   // module vector width before scaling
    localparam int ROTW = 18;   // saturated rotation speed width
    localparam int PRW  = 34;   // rotation times direction product width

    localparam int ATAN_ENTRIES = 24;
    localparam int ROT_LIMIT    = 65535;
    localparam int ANGLE_LIMIT  = 23040;
    localparam int SPEED_LIMIT  = 262143;
    localparam int INV_GAIN     = 39796;
    localparam int DEG90_ACC    = 2949120;

    typedef enum logic [2:0] {
        CFG_GAIN = 3'd0,
        CFG_COS0 = 3'd1,
        CFG_SIN0 = 3'd2,
        CFG_COS1 = 3'd3,
        CFG_SIN1 = 3'd4,
        CFG_COS2 = 3'd5,
        CFG_SIN2 = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [AW-1:0] acc;
        logic [1:0]           idx;
        logic                 last;
        logic                 zero;
    } t_vec;

    localparam logic signed [AW-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
        25'sd1474560, 25'sd870484, 25'sd459940, 25'sd233473,
        25'sd117189,  25'sd58652,  25'sd29333,  25'sd14667,
        25'sd7334,    25'sd3667,   25'sd1833,   25'sd917,
        25'sd458,     25'sd229,    25'sd115,    25'sd57,
        25'sd29,      25'sd14,     25'sd7,      25'sd4,
        25'sd2,       25'sd1,      25'sd0,      25'sd0
    };

endpackage

`default_nettype wire

@@ sv/smk_if.sv @@
// ----------------------------------------------------------------------------
// smk interfaces
// command, result and register write channels
// ----------------------------------------------------------------------------
`default_nettype none

interface smk_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;

    modport source (output valid, output vel_x, output vel_y, output yaw_rate, input ready);
    modport sink   (input valid, input vel_x, input vel_y, input yaw_rate, output ready);
endinterface

interface smk_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         module_index;
    logic signed [15:0] steer_angle;
    logic [17:0]        wheel_speed;
    logic               last;

    modport source (output valid, output module_index, output steer_angle,
                    output wheel_speed, output last, input ready);
    modport sink   (input valid, input module_index, input steer_angle,
                    input wheel_speed, input last, output ready);
endinterface

interface smk_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/swerve_module_kinematics_core.sv @@
// ----------------------------------------------------------------------------
// swerve_module_kinematics_core
// chassis velocity command to steering angle and wheel speed per module
//
//   channel   dir  width        contents
//   i_cmd     in   48           vel_x, vel_y, yaw_rate (q8.8)
//   o_res     out  37           module_index, steer_angle, wheel_speed, last
//   i_cfg     in   3 + 16       register index, write data
//
// one command gives NUM_MODULES results, one per cycle while the output is
// not stalled; the module issuer holds a command until its last module is
// issued, and the command register can hold the next command meanwhile.
// a stalled output freezes the whole chain; the command register still takes
// one command while it is empty. reset clears all valid bits and loads the
// register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module swerve_module_kinematics_core
    import smk_pkg::*;
#(
    parameter int NUM_MODULES  = 3,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    smk_cmd_if.sink    i_cmd,
    smk_cfg_if.sink    i_cfg,
    smk_res_if.source  o_res
);

    logic w_adv;
    logic w_valid [CORDIC_STEPS+1];
    t_vec w_vec   [CORDIC_STEPS+1];

    smk_front #(
        .NUM_MODULES (NUM_MODULES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_cfg   (i_cfg),
        .i_en    (w_adv),
        .o_valid (w_valid[0]),
        .o_vec   (w_vec[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        smk_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_valid[g]),
            .i_vec   (w_vec[g]),
            .o_valid (w_valid[g+1]),
            .o_vec   (w_vec[g+1])
        );
    end

    smk_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[CORDIC_STEPS]),
        .i_vec   (w_vec[CORDIC_STEPS]),
        .o_res   (o_res),
        .o_adv   (w_adv)
    );

endmodule

`default_nettype wire

@@ sv/smk_front.sv @@
// ----------------------------------------------------------------------------
// smk_front
// registers, rotation term, per-module issue and cordic pre-rotation
// ----------------------------------------------------------------------------
`default_nettype none

module smk_front
    import smk_pkg::*;
#(
    parameter int NUM_MODULES = 3
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    smk_cmd_if.sink    i_cmd,
    smk_cfg_if.sink    i_cfg,
    input  wire logic  i_en,
    output logic       o_valid,
    output t_vec       o_vec
);

    logic [15:0]          r_gain;
    logic signed [15:0]   r_cos [3];
    logic signed [15:0]   r_sin [3];

    logic                 r_a_valid;
    logic signed [32:0]   r_a_prod;
    logic signed [15:0]   r_a_vx;
    logic signed [15:0]   r_a_vy;

    logic                 r_b_valid;
    logic [1:0]           r_b_mod;
    logic signed [ROTW-1:0] r_b_rot;
    logic signed [15:0]   r_b_vx;
    logic signed [15:0]   r_b_vy;

    logic                 r_c_valid;
    logic signed [PRW-1:0] r_c_px;
    logic signed [PRW-1:0] r_c_py;
    logic signed [15:0]   r_c_vx;
    logic signed [15:0]   r_c_vy;
    logic [1:0]           r_c_idx;
    logic                 r_c_last;

    logic                 r_d_valid;
    t_vec                 r_d_vec;
    t_vec                 n_d_vec;

    logic                 w_in_acc;
    logic                 w_b_last;
    logic                 w_b_free;
    logic                 w_a_go;
    logic signed [32:0]   w_prod;
    logic signed [32:0]   w_rot_sh;
    logic signed [ROTW-1:0] n_rot;
    logic signed [PRW-1:0] w_px;
    logic signed [PRW-1:0] w_py;
    logic signed [SW-1:0] w_sx;
    logic signed [SW-1:0] w_sy;
    logic signed [XW-1:0] w_x0;
    logic signed [XW-1:0] w_y0;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= 16'd447;
            r_cos[0] <= 16'sd0;
            r_sin[0] <= 16'sd16384;
            r_cos[1] <= -16'sd14189;
            r_sin[1] <= -16'sd8192;
            r_cos[2] <= 16'sd14189;
            r_sin[2] <= -16'sd8192;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_GAIN: r_gain   <= i_cfg.data;
                CFG_COS0: r_cos[0] <= $signed(i_cfg.data);
                CFG_SIN0: r_sin[0] <= $signed(i_cfg.data);
                CFG_COS1: r_cos[1] <= $signed(i_cfg.data);
                CFG_SIN1: r_sin[1] <= $signed(i_cfg.data);
                CFG_COS2: r_cos[2] <= $signed(i_cfg.data);
                CFG_SIN2: r_sin[2] <= $signed(i_cfg.data);
                default: ;
            endcase
        end
    end

    // handshake between command register and module issuer
    assign w_b_last    = (r_b_mod == 2'(NUM_MODULES - 1));
    assign w_b_free    = !r_b_valid || (i_en && w_b_last);
    assign w_a_go      = r_a_valid && w_b_free;
    assign i_cmd.ready = !r_a_valid || w_a_go;
    assign w_in_acc    = i_cmd.valid && i_cmd.ready;

    // stage a: yaw rate times gain
    assign w_prod = $signed(i_cmd.yaw_rate) * $signed({1'b0, r_gain});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_a_valid <= 1'b1;
        end else if (w_a_go) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_prod <= w_prod;
            r_a_vx   <= i_cmd.vel_x;
            r_a_vy   <= i_cmd.vel_y;
        end
    end

    // stage b: saturated rotation speed, one module issued per cycle while i_en is high
    assign w_rot_sh = r_a_prod >>> 8;

    always_comb begin
        if (w_rot_sh > ROT_LIMIT) begin
            n_rot = ROTW'(ROT_LIMIT);
        end else if (w_rot_sh < -ROT_LIMIT) begin
            n_rot = ROTW'(-ROT_LIMIT);
        end else begin
            n_rot = ROTW'(w_rot_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_mod   <= 2'd0;
        end else if (w_a_go) begin
            r_b_valid <= 1'b1;
            r_b_mod   <= 2'd0;
        end else if (i_en && r_b_valid) begin
            if (w_b_last) begin
                r_b_valid <= 1'b0;
            end else begin
                r_b_mod <= r_b_mod + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_go) begin
            r_b_rot <= n_rot;
            r_b_vx  <= r_a_vx;
            r_b_vy  <= r_a_vy;
        end
    end

    // stage c: rotation term along the module direction
    assign w_px = r_b_rot * r_cos[r_b_mod];
    assign w_py = r_b_rot * r_sin[r_b_mod];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_px   <= w_px;
            r_c_py   <= w_py;
            r_c_vx   <= r_b_vx;
            r_c_vy   <= r_b_vy;
            r_c_idx  <= r_b_mod;
            r_c_last <= w_b_last;
        end
    end

    // stage d: module vector, scaled and turned into the right half plane
    assign w_sx = SW'(r_c_px >>> 14) + SW'(r_c_vx);
    assign w_sy = SW'(r_c_py >>> 14) + SW'(r_c_vy);
    assign w_x0 = XW'($signed({w_sx, 8'd0}));
    assign w_y0 = XW'($signed({w_sy, 8'd0}));

    always_comb begin
        n_d_vec      = '0;
        n_d_vec.idx  = r_c_idx;
        n_d_vec.last = r_c_last;
        n_d_vec.zero = (w_sx == '0) && (w_sy == '0);
        if (!w_x0[XW-1]) begin
            n_d_vec.x   = w_x0;
            n_d_vec.y   = w_y0;
            n_d_vec.acc = '0;
        end else if (!w_y0[XW-1]) begin
            n_d_vec.x   = w_y0;
            n_d_vec.y   = -w_x0;
            n_d_vec.acc = AW'(DEG90_ACC);
        end else begin
            n_d_vec.x   = -w_y0;
            n_d_vec.y   = w_x0;
            n_d_vec.acc = AW'(-DEG90_ACC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_vec <= n_d_vec;
        end
    end

    assign o_valid = r_d_valid;
    assign o_vec   = r_d_vec;

endmodule

`default_nettype wire

@@ sv/smk_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// smk_cordic_cell
// one vectoring micro-rotation of the cordic chain
// ----------------------------------------------------------------------------
`default_nettype none

module smk_cordic_cell
    import smk_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_vec i_vec,
    output logic      o_valid,
    output t_vec      o_vec
);

    logic r_valid;
    t_vec r_vec;
    t_vec n_vec;

    // rotate toward the x axis, sign of y picks the direction
    always_comb begin
        n_vec = i_vec;
        if (!i_vec.y[XW-1]) begin
            n_vec.x   = i_vec.x + (i_vec.y >>> STEP);
            n_vec.y   = i_vec.y - (i_vec.x >>> STEP);
            n_vec.acc = i_vec.acc + ATAN_TAB[STEP];
        end else begin
            n_vec.x   = i_vec.x - (i_vec.y >>> STEP);
            n_vec.y   = i_vec.y + (i_vec.x >>> STEP);
            n_vec.acc = i_vec.acc - ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

`default_nettype wire

@@ sv/smk_back.sv @@
// ----------------------------------------------------------------------------
// smk_back
// angle rounding, gain correction of the magnitude and output register
// ----------------------------------------------------------------------------
`default_nettype none

module smk_back
    import smk_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_vec  i_vec,
    smk_res_if.source  o_res,
    output logic       o_adv
);

    logic                 r_e_valid;
    logic signed [15:0]   r_e_angle;
    logic [29:0]          r_e_pl;
    logic [30:0]          r_e_ph;
    logic [1:0]           r_e_idx;
    logic                 r_e_last;
    logic                 r_e_zero;

    logic                 r_out_valid;
    logic [1:0]           r_out_idx;
    logic signed [15:0]   r_out_angle;
    logic [17:0]          r_out_speed;
    logic                 r_out_last;

    logic signed [AW-1:0] w_ang_sh;
    logic signed [15:0]   n_angle;
    logic [XW-2:0]        w_xpos;
    logic [45:0]          w_sum;
    logic [21:0]          w_sp_full;
    logic [17:0]          n_speed;

    assign o_adv = !r_out_valid || o_res.ready;

    // stage e: angle to 1/128 degree, magnitude split for two narrow products
    assign w_ang_sh = (i_vec.acc + AW'(128)) >>> 8;

    always_comb begin
        if (w_ang_sh > ANGLE_LIMIT) begin
            n_angle = 16'(ANGLE_LIMIT);
        end else if (w_ang_sh < -ANGLE_LIMIT) begin
            n_angle = 16'(-ANGLE_LIMIT);
        end else begin
            n_angle = 16'(w_ang_sh);
        end
    end

    assign w_xpos = i_vec.x[XW-1] ? '0 : i_vec.x[XW-2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (o_adv) begin
            r_e_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_e_angle <= n_angle;
            r_e_pl    <= 30'(w_xpos[13:0]) * 30'(INV_GAIN);
            r_e_ph    <= 31'(w_xpos[XW-2:14]) * 31'(INV_GAIN);
            r_e_idx   <= i_vec.idx;
            r_e_last  <= i_vec.last;
            r_e_zero  <= i_vec.zero;
        end
    end

    // stage f: rounded, saturated speed
    assign w_sum     = {1'b0, r_e_ph, 14'd0} + 46'(r_e_pl) + 46'(1 << 23);
    assign w_sp_full = w_sum[45:24];

    always_comb begin
        if (r_e_zero) begin
            n_speed = '0;
        end else if (w_sp_full > 22'(SPEED_LIMIT)) begin
            n_speed = 18'(SPEED_LIMIT);
        end else begin
            n_speed = w_sp_full[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_out_idx   <= r_e_idx;
            r_out_angle <= r_e_zero ? 16'sd0 : r_e_angle;
            r_out_speed <= n_speed;
            r_out_last  <= r_e_last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.module_index = r_out_idx;
    assign o_res.steer_angle  = r_out_angle;
    assign o_res.wheel_speed  = r_out_speed;
    assign o_res.last         = r_out_last;

endmodule

`default_nettype wire

@@ sv/smk_checker.sv @@
// ----------------------------------------------------------------------------
// smk_checker
// result channel checks, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "swerve_module_kinematics_core_assert.svh"

module smk_checker
    import smk_pkg::*;
#(
    parameter int NUM_MODULES = 3
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               i_ready,
    input wire logic [1:0]         i_module_index,
    input wire logic signed [15:0] i_steer_angle,
    input wire logic [17:0]        i_wheel_speed,
    input wire logic               i_last
);

    logic [1:0]  r_exp_idx;
    logic [36:0] w_res;
    logic        w_is_final;
    logic        w_angle_ok;

    // whole result transaction, held while the sink stalls
    assign w_res      = {i_module_index, i_steer_angle, i_wheel_speed, i_last};
    assign w_is_final = (i_module_index == 2'(NUM_MODULES - 1));
    assign w_angle_ok = (i_steer_angle <= ANGLE_LIMIT) && (i_steer_angle >= -ANGLE_LIMIT);

    // next module index expected on the result channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= 2'd0;
        end else if (i_valid && i_ready) begin
            r_exp_idx <= i_last ? 2'd0 : i_module_index + 2'd1;
        end
    end

    `SMK_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(w_res))
    `SMK_ASSERT_NOW(a_res_order, i_clk, i_rst_n, i_valid, i_module_index == r_exp_idx)
    `SMK_ASSERT_NOW(a_res_last, i_clk, i_rst_n, i_valid, i_last == w_is_final)
    `SMK_ASSERT_NOW(a_res_angle, i_clk, i_rst_n, i_valid, w_angle_ok)

endmodule

bind swerve_module_kinematics_core smk_checker #(
    .NUM_MODULES (NUM_MODULES)
) u_smk_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_module_index (o_res.module_index),
    .i_steer_angle  (o_res.steer_angle),
    .i_wheel_speed  (o_res.wheel_speed),
    .i_last         (o_res.last)
);

`default_nettype wire
